// ===== rtl/anfc_pkg.sv =====
// ============================================================================
// anfc_pkg
// Shared types, constants and the arctangent table for the clip plane block.
// ============================================================================
package anfc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Angles in Q.30, held at 34 bits so a full Q2.13 input fits before reduction.
    localparam logic signed [33:0] ANG_PI      = 34'sd3373259426;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [19:0] MARGIN_Q32  = 20'sd429497;
    localparam longint             OUT_MAX     = 64'h7FFF_FFFF;
    localparam int                 TINY_W      = 21;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } anfc_in_t;

    typedef struct packed {
        logic [30:0] near_depth;
        logic [30:0] far_depth;
    } anfc_out_t;

    // Box corners relative to the camera, plus the smallest box extent.
    typedef struct packed {
        logic signed [32:0] lo_x;
        logic signed [32:0] lo_y;
        logic signed [32:0] lo_z;
        logic signed [32:0] hi_x;
        logic signed [32:0] hi_y;
        logic signed [32:0] hi_z;
        logic signed [32:0] ext;
    } anfc_rel_t;

    function automatic logic signed [31:0] atan_q30(input int idx);
        logic signed [31:0] r;
        case (idx)
            0:  r = 32'sd843314857;
            1:  r = 32'sd497837829;
            2:  r = 32'sd263043837;
            3:  r = 32'sd133525159;
            4:  r = 32'sd67021687;
            5:  r = 32'sd33543516;
            6:  r = 32'sd16775851;
            7:  r = 32'sd8388437;
            8:  r = 32'sd4194283;
            9:  r = 32'sd2097149;
            10: r = 32'sd1048576;
            11: r = 32'sd524288;
            12: r = 32'sd262144;
            13: r = 32'sd131072;
            14: r = 32'sd65536;
            15: r = 32'sd32768;
            16: r = 32'sd16384;
            17: r = 32'sd8192;
            18: r = 32'sd4096;
            19: r = 32'sd2048;
            20: r = 32'sd1024;
            21: r = 32'sd512;
            22: r = 32'sd256;
            23: r = 32'sd128;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/anfc_cordic.sv =====
// ============================================================================
// anfc_cordic
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage.
// ============================================================================
module anfc_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);
    import anfc_pkg::*;

    logic signed [31:0] x_reg [0:CORDIC_STEPS];
    logic signed [31:0] y_reg [0:CORDIC_STEPS];
    logic signed [31:0] a_reg [0:CORDIC_STEPS];
    logic               neg_reg [0:CORDIC_STEPS];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    logic signed [33:0] a_full;
    logic signed [33:0] a_red;
    logic               neg_next;

    // Angles past a quarter turn are folded by pi; the result is negated at the end.
    always_comb begin
        a_full   = {angle[15], angle, 17'b0};
        a_red    = a_full;
        neg_next = 1'b0;
        if (a_full > ANG_HALF_PI) begin
            a_red    = a_full - ANG_PI;
            neg_next = 1'b1;
        end else if (a_full < -ANG_HALF_PI) begin
            a_red    = a_full + ANG_PI;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            a_reg[0]   <= a_red[31:0];
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (a_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_q30(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== rtl/anfc_depth.sv =====
// ============================================================================
// anfc_depth
// View direction, corner projection, min/max and margin clamp, six stages.
// ============================================================================
module anfc_depth #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [31:0]   cp,
    input  logic signed [31:0]   sp,
    input  logic signed [31:0]   cy,
    input  logic signed [31:0]   sy,
    input  anfc_pkg::anfc_rel_t  rel,
    output anfc_pkg::anfc_out_t  result
);
    import anfc_pkg::*;

    localparam int DW   = FRAC_BITS + 3;
    localparam int PW   = 33 + DW;
    localparam int SW   = PW + 2;
    localparam int DEPW = SW - FRAC_BITS;
    localparam int VW   = DEPW + 1;
    localparam logic signed [VW-1:0] VMAX = VW'(OUT_MAX);

    // Stage D: direction vector and margin.
    logic signed [63:0]     pxy, pzz;
    logic signed [52:0]     tprod;
    logic signed [DW-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [TINY_W-1:0] tiny_d_reg;
    anfc_rel_t              rel_reg;

    assign pxy   = cp * sy;
    assign pzz   = cp * cy;
    assign tprod = rel.ext * MARGIN_Q32;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= DW'(-(pxy >>> (60 - FRAC_BITS)));
            dy_reg     <= DW'(sp >>> (30 - FRAC_BITS));
            dz_reg     <= DW'(-(pzz >>> (60 - FRAC_BITS)));
            tiny_d_reg <= TINY_W'(tprod >>> 32);
            rel_reg    <= rel;
        end
    end

    // Stage E: each axis has only two distinct corner coordinates.
    logic signed [PW-1:0]     pxl_reg, pxh_reg, pyl_reg, pyh_reg, pzl_reg, pzh_reg;
    logic signed [TINY_W-1:0] tiny_e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxl_reg    <= rel_reg.lo_x * dx_reg;
            pxh_reg    <= rel_reg.hi_x * dx_reg;
            pyl_reg    <= rel_reg.lo_y * dy_reg;
            pyh_reg    <= rel_reg.hi_y * dy_reg;
            pzl_reg    <= rel_reg.lo_z * dz_reg;
            pzh_reg    <= rel_reg.hi_z * dz_reg;
            tiny_e_reg <= tiny_d_reg;
        end
    end

    // Stage F: eight corner depths.
    logic signed [DEPW-1:0]   dep_reg [0:7];
    logic signed [DEPW-1:0]   dep_next [0:7];
    logic signed [TINY_W-1:0] tiny_f_reg;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            logic signed [SW-1:0] sum;
            sum = SW'(c[2] ? pxh_reg : pxl_reg) + SW'(c[1] ? pyh_reg : pyl_reg)
                + SW'(c[0] ? pzh_reg : pzl_reg);
            dep_next[c] = DEPW'(sum >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dep_reg    <= dep_next;
            tiny_f_reg <= tiny_e_reg;
        end
    end

    // Stage G: pairwise min and max.
    logic signed [DEPW-1:0]   mn4_reg [0:3];
    logic signed [DEPW-1:0]   mx4_reg [0:3];
    logic signed [TINY_W-1:0] tiny_g_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                mn4_reg[j] <= (dep_reg[2*j+1] < dep_reg[2*j]) ? dep_reg[2*j+1] : dep_reg[2*j];
                mx4_reg[j] <= (dep_reg[2*j+1] > dep_reg[2*j]) ? dep_reg[2*j+1] : dep_reg[2*j];
            end
            tiny_g_reg <= tiny_f_reg;
        end
    end

    // Stage H: reduce four to one.
    logic signed [DEPW-1:0]   mn_a, mn_b, mx_a, mx_b;
    logic signed [DEPW-1:0]   mn_reg, mx_reg;
    logic signed [TINY_W-1:0] tiny_h_reg;

    assign mn_a = (mn4_reg[1] < mn4_reg[0]) ? mn4_reg[1] : mn4_reg[0];
    assign mn_b = (mn4_reg[3] < mn4_reg[2]) ? mn4_reg[3] : mn4_reg[2];
    assign mx_a = (mx4_reg[1] > mx4_reg[0]) ? mx4_reg[1] : mx4_reg[0];
    assign mx_b = (mx4_reg[3] > mx4_reg[2]) ? mx4_reg[3] : mx4_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_reg     <= (mn_b < mn_a) ? mn_b : mn_a;
            mx_reg     <= (mx_b > mx_a) ? mx_b : mx_a;
            tiny_h_reg <= tiny_g_reg;
        end
    end

    // Stage I: widen by the margin and clamp. An inverted box gives a
    // negative margin, and then the lower bound is zero.
    logic signed [VW-1:0] lb, near_v, far_v;
    anfc_out_t            out_reg;

    always_comb begin
        lb     = (tiny_h_reg < 0) ? '0 : VW'(tiny_h_reg);
        near_v = VW'(mn_reg) - VW'(tiny_h_reg);
        far_v  = VW'(mx_reg) + VW'(tiny_h_reg);
        if (near_v < lb) begin
            near_v = lb;
        end else if (near_v > VMAX) begin
            near_v = VMAX;
        end
        if (far_v < lb) begin
            far_v = lb;
        end else if (far_v > VMAX) begin
            far_v = VMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.near_depth <= near_v[30:0];
            out_reg.far_depth  <= far_v[30:0];
        end
    end

    assign result = out_reg;

endmodule

// ===== rtl/auto_near_far_clip_planes.sv =====
// ============================================================================
// auto_near_far_clip_planes
// Near and far clip distances for a camera looking at an axis-aligned box.
// ============================================================================
// Usage:
//   Input transactions on s_valid/s_ready carry pitch, yaw, the camera position
//   and the box corners as one packed struct. Each produces exactly one result
//   transaction on m_valid/m_ready with near_depth and far_depth (Q15.16).
//   The pipeline has one angle folding stage, one CORDIC stage per
//   micro-rotation, a sign stage, then six stages for direction, corner
//   products, depth sums, two min/max levels and the clamp. Throughput is
//   one transaction per cycle while m_ready does not stall the output.
//   All stages advance together; when the receiver holds m_ready low while a
//   result is waiting, the whole pipeline freezes and s_ready drops, so no
//   transaction is lost or repeated. Reset (aresetn low, synchronous) clears
//   every valid bit; data registers are not reset.
// ============================================================================
module auto_near_far_clip_planes #(
    parameter int FRAC_BITS    = anfc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = anfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  anfc_pkg::anfc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output anfc_pkg::anfc_out_t m_data
);
    import anfc_pkg::*;

    localparam int LAT   = CORDIC_STEPS + 8;
    localparam int RDLY  = CORDIC_STEPS + 2;

    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;

    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign vld_next = {vld_reg[LAT-2:0], s_valid};
    assign m_valid  = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Relative corners and smallest extent, delayed to meet the CORDIC outputs.
    anfc_rel_t          rel_next;
    anfc_rel_t          rel_reg [0:RDLY-1];
    logic signed [32:0] ex, ey, ez, emin;

    always_comb begin
        rel_next.lo_x = 33'(s_data.box_min_x) - 33'(s_data.cam_x);
        rel_next.lo_y = 33'(s_data.box_min_y) - 33'(s_data.cam_y);
        rel_next.lo_z = 33'(s_data.box_min_z) - 33'(s_data.cam_z);
        rel_next.hi_x = 33'(s_data.box_max_x) - 33'(s_data.cam_x);
        rel_next.hi_y = 33'(s_data.box_max_y) - 33'(s_data.cam_y);
        rel_next.hi_z = 33'(s_data.box_max_z) - 33'(s_data.cam_z);
        ex = 33'(s_data.box_max_x) - 33'(s_data.box_min_x);
        ey = 33'(s_data.box_max_y) - 33'(s_data.box_min_y);
        ez = 33'(s_data.box_max_z) - 33'(s_data.box_min_z);
        emin = ex;
        if (ey < emin) begin
            emin = ey;
        end
        if (ez < emin) begin
            emin = ez;
        end
        rel_next.ext = emin;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rel_reg[0] <= rel_next;
            for (int k = 1; k < RDLY; k++) begin
                rel_reg[k] <= rel_reg[k-1];
            end
        end
    end

    logic signed [31:0] cp, sp, cy, sy;

    anfc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .aclk  (aclk),
        .en    (en),
        .angle (s_data.pitch),
        .cos_q (cp),
        .sin_q (sp)
    );

    anfc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .aclk  (aclk),
        .en    (en),
        .angle (s_data.yaw),
        .cos_q (cy),
        .sin_q (sy)
    );

    anfc_depth #(.FRAC_BITS(FRAC_BITS)) u_depth (
        .aclk   (aclk),
        .en     (en),
        .cp     (cp),
        .sp     (sp),
        .cy     (cy),
        .sy     (sy),
        .rel    (rel_reg[RDLY-1]),
        .result (m_data)
    );

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("pipeline valid bits not cleared by reset");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

endmodule
